// ----- src/assert_macros.svh -----
// assertion helpers included by the top-level rtl file
// each macro checks on the rising edge of clk and is quiet while arst_n is low
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every clock edge out of reset
`define JSU_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// condition must never be seen at a clock edge out of reset
`define JSU_NEVER(lbl, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) !(cond)) else $error(msg);

`endif

// ----- src/jsu_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jsu_pkg
// Types and constants shared by the JSON string unescape front, queue and
// back end.
// ----------------------------------------------------------------------------
package jsu_pkg;

	// error codes carried on error_kind
	localparam logic [2:0] ERR_NONE       = 3'd0;
	localparam logic [2:0] ERR_NO_OPEN    = 3'd1;
	localparam logic [2:0] ERR_BAD_ESCAPE = 3'd2;
	localparam logic [2:0] ERR_BAD_HEX    = 3'd3;
	localparam logic [2:0] ERR_SHORT_HEX  = 3'd4;

	// utf-8 encoding constants
	localparam logic [15:0] UTF_MAX1  = 16'h007F;
	localparam logic [15:0] UTF_MAX2  = 16'h07FF;
	localparam logic [7:0]  UTF_LEAD2 = 8'hC0;
	localparam logic [7:0]  UTF_LEAD3 = 8'hE0;
	localparam logic [7:0]  UTF_CONT  = 8'h80;
	localparam logic [7:0]  UTF_MASK6 = 8'h3F;

	// default depth of the job queue between front and back
	localparam int QUEUE_DEPTH = 4;

	// what the back end has to produce for one job
	typedef enum logic [2:0] {
		OP_BYTE = 3'd0,
		OP_DONE = 3'd1,
		OP_ERR  = 3'd2,
		OP_UTF2 = 3'd3,
		OP_UTF3 = 3'd4
	} op_t;

	// one queued job: op, byte or 16-bit code point, error code
	typedef struct packed {
		op_t         op;
		logic [15:0] data;
		logic [2:0]  err;
	} job_t;

	// front end decoder state
	typedef enum logic [3:0] {
		MODE_IDLE = 4'b0001,
		MODE_STR  = 4'b0010,
		MODE_ESC  = 4'b0100,
		MODE_HEX  = 4'b1000
	} mode_t;

endpackage

// ----- src/jsu_front.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jsu_front
// Takes raw literal bytes, tracks quote, escape and \u state, and pushes one
// job per byte that yields output into the queue.
// ----------------------------------------------------------------------------
module jsu_front (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	output logic            in_ready,
	input  logic [7:0]      in_byte,
	input  logic            q_full,
	output logic            q_push,
	output jsu_pkg::job_t   q_job
);

	localparam logic [7:0] CH_QUOTE = 8'h22;
	localparam logic [7:0] CH_BSL   = 8'h5C;
	localparam logic [7:0] CH_SLASH = 8'h2F;
	localparam logic [7:0] CH_B     = 8'h62;
	localparam logic [7:0] CH_F     = 8'h66;
	localparam logic [7:0] CH_N     = 8'h6E;
	localparam logic [7:0] CH_R     = 8'h72;
	localparam logic [7:0] CH_T     = 8'h74;
	localparam logic [7:0] CH_U     = 8'h75;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_TAB   = 8'h09;
	localparam logic [7:0] CH_CR    = 8'h0D;

	// hex digit decode: {is_hex, value}
	function automatic logic [4:0] hex_decode(input logic [7:0] c);
		logic [4:0] r;
		r = 5'd0;
		if (c >= 8'h30 && c <= 8'h39) begin
			r = {1'b1, 4'(c - 8'h30)};
		end else if (c >= 8'h41 && c <= 8'h46) begin
			r = {1'b1, 4'(c - 8'h37)};
		end else if (c >= 8'h61 && c <= 8'h66) begin
			r = {1'b1, 4'(c - 8'h57)};
		end
		return r;
	endfunction

	jsu_pkg::mode_t mode_q, mode_d;
	logic [1:0]     hex_cnt_q, hex_cnt_d;
	logic [11:0]    acc_q, acc_d;
	logic [4:0]     hex;
	logic [15:0]    code;
	logic           accept;
	logic           is_ws;

	assign in_ready = !q_full;
	assign accept   = in_valid && in_ready;
	assign hex      = hex_decode(in_byte);
	assign code     = {acc_q, hex[3:0]};
	assign is_ws    = (in_byte == CH_SPACE) || (in_byte >= CH_TAB && in_byte <= CH_CR);

	// next state and job classification
	always_comb begin
		mode_d     = mode_q;
		hex_cnt_d  = hex_cnt_q;
		acc_d      = acc_q;
		q_push     = 1'b0;
		q_job.op   = jsu_pkg::OP_BYTE;
		q_job.data = {8'h00, in_byte};
		q_job.err  = jsu_pkg::ERR_NONE;
		case (mode_q)
			jsu_pkg::MODE_IDLE: begin
				if (in_byte == CH_QUOTE) begin
					mode_d = jsu_pkg::MODE_STR;
				end else if (!is_ws) begin
					q_push    = 1'b1;
					q_job.op  = jsu_pkg::OP_ERR;
					q_job.err = jsu_pkg::ERR_NO_OPEN;
				end
			end
			jsu_pkg::MODE_STR: begin
				if (in_byte == CH_QUOTE) begin
					mode_d   = jsu_pkg::MODE_IDLE;
					q_push   = 1'b1;
					q_job.op = jsu_pkg::OP_DONE;
				end else if (in_byte == CH_BSL) begin
					mode_d = jsu_pkg::MODE_ESC;
				end else begin
					q_push = 1'b1;
				end
			end
			jsu_pkg::MODE_ESC: begin
				mode_d = jsu_pkg::MODE_STR;
				q_push = 1'b1;
				case (in_byte)
					CH_QUOTE, CH_BSL, CH_SLASH: q_job.data = {8'h00, in_byte};
					CH_B: q_job.data = 16'h0008;
					CH_F: q_job.data = 16'h000C;
					CH_N: q_job.data = 16'h000A;
					CH_R: q_job.data = 16'h000D;
					CH_T: q_job.data = 16'h0009;
					CH_U: begin
						mode_d    = jsu_pkg::MODE_HEX;
						hex_cnt_d = 2'd0;
						acc_d     = 12'd0;
						q_push    = 1'b0;
					end
					default: begin
						mode_d    = jsu_pkg::MODE_IDLE;
						q_job.op  = jsu_pkg::OP_ERR;
						q_job.err = jsu_pkg::ERR_BAD_ESCAPE;
					end
				endcase
			end
			jsu_pkg::MODE_HEX: begin
				if (!hex[4]) begin
					mode_d    = jsu_pkg::MODE_IDLE;
					hex_cnt_d = 2'd0;
					acc_d     = 12'd0;
					q_push    = 1'b1;
					q_job.op  = jsu_pkg::OP_ERR;
					q_job.err = (in_byte == CH_QUOTE) ? jsu_pkg::ERR_SHORT_HEX
						: jsu_pkg::ERR_BAD_HEX;
				end else if (hex_cnt_q != 2'd3) begin
					acc_d     = {acc_q[7:0], hex[3:0]};
					hex_cnt_d = hex_cnt_q + 2'd1;
				end else begin
					mode_d     = jsu_pkg::MODE_STR;
					hex_cnt_d  = 2'd0;
					acc_d      = 12'd0;
					q_push     = 1'b1;
					q_job.data = code;
					if (code <= jsu_pkg::UTF_MAX1) begin
						q_job.op = jsu_pkg::OP_BYTE;
					end else if (code <= jsu_pkg::UTF_MAX2) begin
						q_job.op = jsu_pkg::OP_UTF2;
					end else begin
						q_job.op = jsu_pkg::OP_UTF3;
					end
				end
			end
			default: begin
				mode_d = jsu_pkg::MODE_IDLE;
			end
		endcase
		if (!accept) begin
			q_push = 1'b0;
		end
	end

	// decoder state registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q    <= jsu_pkg::MODE_IDLE;
			hex_cnt_q <= 2'd0;
			acc_q     <= 12'd0;
		end else if (accept) begin
			mode_q    <= mode_d;
			hex_cnt_q <= hex_cnt_d;
			acc_q     <= acc_d;
		end
	end

endmodule

// ----- src/jsu_fifo.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jsu_fifo
// Small job queue that decouples the front end from the back end.
// ----------------------------------------------------------------------------
module jsu_fifo #(
	parameter int Depth = jsu_pkg::QUEUE_DEPTH
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  jsu_pkg::job_t push_job,
	input  logic          pop,
	output jsu_pkg::job_t head_job,
	output logic          full,
	output logic          empty
);

	localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
	localparam int CntW = $clog2(Depth + 1);

	jsu_pkg::job_t   mem_q [Depth];
	logic [PtrW-1:0] wr_ptr_q;
	logic [PtrW-1:0] rd_ptr_q;
	logic [CntW-1:0] cnt_q;
	logic            do_push;
	logic            do_pop;

	assign full     = (cnt_q == CntW'(Depth));
	assign empty    = (cnt_q == '0);
	assign do_push  = push && !full;
	assign do_pop   = pop && !empty;
	assign head_job = mem_q[rd_ptr_q];

	// storage
	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_job;
		end
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (do_pop && !do_push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

endmodule

// ----- src/jsu_back.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jsu_back
// Expands queued jobs into one to three result words and holds them in the
// output register until taken.
// ----------------------------------------------------------------------------
module jsu_back (
	input  logic          clk,
	input  logic          arst_n,
	input  jsu_pkg::job_t head_job,
	input  logic          q_empty,
	output logic          q_pop,
	output logic          out_valid,
	input  logic          out_ready,
	output logic [7:0]    out_byte,
	output logic          byte_valid,
	output logic          last_of_run,
	output logic          string_done,
	output logic [2:0]    error_kind
);

	logic [1:0] idx_q;
	logic       out_valid_q;
	logic [7:0] byte_q;
	logic       bvalid_q;
	logic       last_q;
	logic       done_q;
	logic [2:0] err_q;
	logic       issue;
	logic [7:0] nbyte;
	logic       nbvalid;
	logic       nlast;
	logic       ndone;
	logic [2:0] nerr;

	assign issue = !q_empty && (!out_valid_q || out_ready);
	assign q_pop = issue && nlast;

	// build the word for the current position within the job
	always_comb begin
		nbyte   = 8'h00;
		nbvalid = 1'b0;
		nlast   = 1'b1;
		ndone   = 1'b0;
		nerr    = jsu_pkg::ERR_NONE;
		case (head_job.op)
			jsu_pkg::OP_BYTE: begin
				nbyte   = head_job.data[7:0];
				nbvalid = 1'b1;
			end
			jsu_pkg::OP_DONE: begin
				ndone = 1'b1;
			end
			jsu_pkg::OP_ERR: begin
				nerr = head_job.err;
			end
			jsu_pkg::OP_UTF2: begin
				nbvalid = 1'b1;
				nlast   = (idx_q == 2'd1);
				if (idx_q == 2'd0) begin
					nbyte = jsu_pkg::UTF_LEAD2 | {3'b000, head_job.data[10:6]};
				end else begin
					nbyte = jsu_pkg::UTF_CONT | ({2'b00, head_job.data[5:0]}
						& jsu_pkg::UTF_MASK6);
				end
			end
			jsu_pkg::OP_UTF3: begin
				nbvalid = 1'b1;
				nlast   = (idx_q == 2'd2);
				if (idx_q == 2'd0) begin
					nbyte = jsu_pkg::UTF_LEAD3 | {4'b0000, head_job.data[15:12]};
				end else if (idx_q == 2'd1) begin
					nbyte = jsu_pkg::UTF_CONT | ({2'b00, head_job.data[11:6]}
						& jsu_pkg::UTF_MASK6);
				end else begin
					nbyte = jsu_pkg::UTF_CONT | ({2'b00, head_job.data[5:0]}
						& jsu_pkg::UTF_MASK6);
				end
			end
			default: begin
				nlast = 1'b1;
			end
		endcase
	end

	// position within job and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q       <= 2'd0;
			out_valid_q <= 1'b0;
		end else begin
			if (issue) begin
				idx_q       <= nlast ? 2'd0 : idx_q + 2'd1;
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// output word register
	always_ff @(posedge clk) begin
		if (issue) begin
			byte_q   <= nbyte;
			bvalid_q <= nbvalid;
			last_q   <= nlast;
			done_q   <= ndone;
			err_q    <= nerr;
		end
	end

	assign out_valid   = out_valid_q;
	assign out_byte    = byte_q;
	assign byte_valid  = bvalid_q;
	assign last_of_run = last_q;
	assign string_done = done_q;
	assign error_kind  = err_q;

endmodule

// ----- src/json_string_unescape.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// json_string_unescape
// Streaming decoder for one JSON string literal at a time: escapes, \uXXXX
// to UTF-8, closing quote and error reporting.
// ----------------------------------------------------------------------------
// Usage:
//  - input channel in_valid/in_ready/in_byte takes one raw byte per word,
//    starting with the opening quote; whitespace before it is skipped
//  - output channel out_valid/out_ready carries result words: out_byte with
//    byte_valid, last_of_run on the final word of an input byte,
//    string_done on the closing quote, error_kind on a decode error
//  - a byte yields zero to three words; the opening quote, backslash, 'u'
//    and the first three hex digits yield none
//  - a job is written into the queue at the accepting edge and passes on
//    to the output register, which raises out_valid, once that is free
//  - throughput is one input byte and one output word per cycle while the
//    queue has room and the receiver is ready; the three words of a 3-byte
//    UTF-8 sequence are covered by the five silent input bytes of its escape
//  - the front accepts while the job queue has room; when the receiver
//    stalls the output word holds and the queue fills before in_ready drops
//  - reset clears the decoder to idle awaiting an opening quote and empties
//    the queue and output register; after an error the decoder is idle
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module json_string_unescape #(
	parameter int QueueDepth = jsu_pkg::QUEUE_DEPTH
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [7:0] in_byte,
	output logic       out_valid,
	input  logic       out_ready,
	output logic [7:0] out_byte,
	output logic       byte_valid,
	output logic       last_of_run,
	output logic       string_done,
	output logic [2:0] error_kind
);

	jsu_pkg::job_t push_job;
	jsu_pkg::job_t head_job;
	logic          q_push;
	logic          q_pop;
	logic          q_full;
	logic          q_empty;
	logic          done_bad;
	logic          data_bad;

	// byte classification
	jsu_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.in_byte  (in_byte),
		.q_full   (q_full),
		.q_push   (q_push),
		.q_job    (push_job)
	);

	// job queue
	jsu_fifo #(
		.Depth (QueueDepth)
	) u_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (q_push),
		.push_job (push_job),
		.pop      (q_pop),
		.head_job (head_job),
		.full     (q_full),
		.empty    (q_empty)
	);

	// result expansion and output register
	jsu_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.head_job    (head_job),
		.q_empty     (q_empty),
		.q_pop       (q_pop),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.out_byte    (out_byte),
		.byte_valid  (byte_valid),
		.last_of_run (last_of_run),
		.string_done (string_done),
		.error_kind  (error_kind)
	);

	// malformed output word shapes
	assign done_bad = string_done && (!last_of_run || byte_valid);
	assign data_bad = byte_valid && (string_done || error_kind != jsu_pkg::ERR_NONE);

	// checks
	`JSU_NEVER(a_push_full, q_push && q_full, "job pushed into full queue")
	`JSU_NEVER(a_pop_empty, q_pop && q_empty, "job popped from empty queue")
	`JSU_NEVER(a_done_last, out_valid && done_bad, "closing quote word malformed")
	`JSU_NEVER(a_data_no_err, out_valid && data_bad, "data word carries status")

endmodule
